// ===== src/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared types and arithmetic steps
// Stage types and single-step square root helpers used by the pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int InW      = 240;   // nine Q1.14 elements and three Q16.16 words
  localparam int OutW     = 160;   // three Q16.16 words and four Q1.14 words
  localparam int Sq1Steps = 23;    // root bits of a candidate
  localparam int Sq2Steps = 24;    // root bits of the norm
  localparam int DivSteps = 15;    // quotient bits of an output magnitude

  // Translation words and the six sign terms travel beside the arithmetic.
  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [5:0]  neg6;  // m7-m5, m2-m6, m3-m1, m3+m1, m2+m6, m7+m5 (bit 0 up)
  } side_t;

  // Digit-by-digit square root state for the candidates.
  typedef struct packed {
    logic [45:0] rad;
    logic [24:0] rem;
    logic [22:0] root;
  } sq1_t;

  // Digit-by-digit square root state for the norm.
  typedef struct packed {
    logic [47:0] rad;
    logic [25:0] rem;
    logic [23:0] root;
  } sq2_t;

  // One result bit of the candidate square root.
  function automatic sq1_t sq1_step(sq1_t a);
    logic [26:0] wide;
    logic [26:0] trial;
    sq1_t        o;
    wide  = {a.rem, a.rad[45:44]};
    trial = {2'b00, a.root, 2'b01};
    o.rad = {a.rad[43:0], 2'b00};
    if (wide >= trial) begin
      o.rem  = 25'(wide - trial);
      o.root = {a.root[21:0], 1'b1};
    end else begin
      o.rem  = wide[24:0];
      o.root = {a.root[21:0], 1'b0};
    end
    return o;
  endfunction

  // One result bit of the norm square root.
  function automatic sq2_t sq2_step(sq2_t a);
    logic [27:0] wide;
    logic [27:0] trial;
    sq2_t        o;
    wide  = {a.rem, a.rad[47:46]};
    trial = {2'b00, a.root, 2'b01};
    o.rad = {a.rad[45:0], 2'b00};
    if (wide >= trial) begin
      o.rem  = 26'(wide - trial);
      o.root = {a.root[22:0], 1'b1};
    end else begin
      o.rem  = wide[25:0];
      o.root = {a.root[22:0], 1'b0};
    end
    return o;
  endfunction

  // Component sign flags (bit k set means negative) for the winning branch.
  function automatic logic [3:0] neg_sel(logic [1:0] best, logic [5:0] n6);
    logic [3:0] o;
    case (best)
      2'd0:    o = {n6[2], n6[1], n6[0], 1'b0};
      2'd1:    o = {n6[4], n6[3], 1'b0, n6[0]};
      2'd2:    o = {n6[5], 1'b0, n6[3], n6[1]};
      2'd3:    o = {1'b0, n6[5], n6[4], n6[2]};
      default: o = 4'b0000;
    endcase
    return o;
  endfunction

endpackage

// ===== src/rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Converts a Q1.14 rotation matrix to a unit quaternion, translation beside.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one pose request per handshake: nine Q1.14 matrix
//   elements and a Q16.16 translation. The out_ channel returns one request
//   per pose with the translation unchanged and the quaternion x, y, z, w in
//   Q1.14, in input order.
//   Throughput is one pose per cycle while out_tready does not hold the
//   pipeline: the candidate square roots, the norm square root and the
//   four dividers are each unrolled into one register stage per result
//   bit, so every stage holds a different pose.
//   Reset (rst_n low at a clock edge) empties the pipeline; no request is
//   pending afterwards and no clearing pass is needed.
//   When the receiver holds out_tready low while a result waits, the whole
//   pipeline freezes and in_tready drops in the same cycle; nothing is lost
//   or repeated, and work resumes on the cycle out_tready returns.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, tx_in, ty_in, tz_in
  input  logic [rmq_pkg::InW-1:0]   in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // tx_out, ty_out, tz_out, quat_x, quat_y, quat_z, quat_w
  output logic [rmq_pkg::OutW-1:0]  out_tdata
);
  import rmq_pkg::*;

  // Pipeline advance: everything moves unless a finished result is stuck.
  logic en;
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  // Input field unpacking and the candidate sums.
  logic signed [15:0] m [0:8];
  logic signed [18:0] s [0:3];
  logic [16:0]        c [0:3];
  logic signed [16:0] t [0:5];
  side_t              side_in;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = in_tdata[16*i +: 16];
    end
    s[0] = 19'(m[0]) + 19'(m[4]) + 19'(m[8]) + 19'sd16384;
    s[1] = 19'(m[0]) - 19'(m[4]) - 19'(m[8]) + 19'sd16384;
    s[2] = -19'(m[0]) + 19'(m[4]) - 19'(m[8]) + 19'sd16384;
    s[3] = -19'(m[0]) - 19'(m[4]) + 19'(m[8]) + 19'sd16384;
    for (int k = 0; k < 4; k++) begin
      c[k] = (s[k] > 19'sd0) ? s[k][16:0] : 17'd0;
    end
    t[0] = 17'(m[7]) - 17'(m[5]);
    t[1] = 17'(m[2]) - 17'(m[6]);
    t[2] = 17'(m[3]) - 17'(m[1]);
    t[3] = 17'(m[3]) + 17'(m[1]);
    t[4] = 17'(m[2]) + 17'(m[6]);
    t[5] = 17'(m[7]) + 17'(m[5]);
    side_in.tx = in_tdata[144 +: 32];
    side_in.ty = in_tdata[176 +: 32];
    side_in.tz = in_tdata[208 +: 32];
    for (int j = 0; j < 6; j++) begin
      side_in.neg6[j] = t[j][16];
    end
  end

  // Candidate square root pipeline, stage 0 is the input register.
  logic [Sq1Steps:0] v1_r;
  sq1_t              s1_r   [0:Sq1Steps][0:3];
  side_t             side1_r[0:Sq1Steps];

  // Square and winner stage.
  logic        sq_v_r;
  logic [22:0] sq_root_r [0:3];
  logic [45:0] sq_pow_r  [0:3];
  logic [1:0]  sq_best_r;
  side_t       sq_side_r;
  logic [1:0]  best;

  // Norm square root pipeline, stage 0 holds the sum of squares.
  logic [Sq2Steps:0] v2_r;
  sq2_t              s2_r     [0:Sq2Steps];
  logic [22:0]       root2_r  [0:Sq2Steps][0:3];
  logic [3:0]        neg2_r   [0:Sq2Steps];
  side_t             side2_r  [0:Sq2Steps];
  logic [1:0]        sum_best_r;

  // Divider pipeline, stage 0 holds the rounded numerators.
  logic [DivSteps:0] vd_r;
  logic [37:0]       drem_r [0:DivSteps][0:3];
  logic [14:0]       dq_r   [0:DivSteps][0:3];
  logic [23:0]       dn_r   [0:DivSteps];
  logic [3:0]        dneg_r [0:DivSteps];
  side_t             dside_r[0:DivSteps];

  // Output register.
  logic        out_v_r;
  logic [15:0] quat_r [0:3];
  side_t       oside_r;

  // Largest root wins, ties to the lower index.
  always_comb begin
    best = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (s1_r[Sq1Steps][k].root > s1_r[Sq1Steps][best].root) begin
        best = 2'(k);
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= '0;
      sq_v_r  <= 1'b0;
      v2_r    <= '0;
      vd_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= {v1_r[Sq1Steps-1:0], in_tvalid};
      sq_v_r  <= v1_r[Sq1Steps];
      v2_r    <= {v2_r[Sq2Steps-1:0], sq_v_r};
      vd_r    <= {vd_r[DivSteps-1:0], v2_r[Sq2Steps]};
      out_v_r <= vd_r[DivSteps];
    end
  end

  // Payload of every stage.
  always_ff @(posedge clk) begin
    if (en) begin
      // Candidate roots: c scaled by 2^28.
      side1_r[0] <= side_in;
      for (int k = 0; k < 4; k++) begin
        s1_r[0][k].rad  <= {1'b0, c[k], 28'd0};
        s1_r[0][k].rem  <= '0;
        s1_r[0][k].root <= '0;
      end
      for (int i = 0; i < Sq1Steps; i++) begin
        side1_r[i+1] <= side1_r[i];
        for (int k = 0; k < 4; k++) begin
          s1_r[i+1][k] <= sq1_step(s1_r[i][k]);
        end
      end

      // Squares and winning branch.
      for (int k = 0; k < 4; k++) begin
        sq_root_r[k] <= s1_r[Sq1Steps][k].root;
        sq_pow_r[k]  <= 46'({23'd0, s1_r[Sq1Steps][k].root} *
                            {23'd0, s1_r[Sq1Steps][k].root});
      end
      sq_best_r <= best;
      sq_side_r <= side1_r[Sq1Steps];

      // Sum of squares and the branch signs.
      s2_r[0].rad <= {2'b00, sq_pow_r[0]} + {2'b00, sq_pow_r[1]} +
                     {2'b00, sq_pow_r[2]} + {2'b00, sq_pow_r[3]};
      s2_r[0].rem  <= '0;
      s2_r[0].root <= '0;
      neg2_r[0]    <= neg_sel(sq_best_r, sq_side_r.neg6);
      side2_r[0]   <= sq_side_r;
      sum_best_r   <= sq_best_r;
      for (int k = 0; k < 4; k++) begin
        root2_r[0][k] <= sq_root_r[k];
      end
      for (int i = 0; i < Sq2Steps; i++) begin
        s2_r[i+1]    <= sq2_step(s2_r[i]);
        neg2_r[i+1]  <= neg2_r[i];
        side2_r[i+1] <= side2_r[i];
        for (int k = 0; k < 4; k++) begin
          root2_r[i+1][k] <= root2_r[i][k];
        end
      end

      // Rounded numerators r * 2^14 + n / 2.
      dn_r[0]    <= s2_r[Sq2Steps].root;
      dneg_r[0]  <= neg2_r[Sq2Steps];
      dside_r[0] <= side2_r[Sq2Steps];
      for (int k = 0; k < 4; k++) begin
        drem_r[0][k] <= {1'b0, root2_r[Sq2Steps][k], 14'd0} +
                        {15'd0, s2_r[Sq2Steps].root[23:1]};
        dq_r[0][k]   <= '0;
      end

      // Restoring division, one quotient bit per stage.
      for (int j = 0; j < DivSteps; j++) begin
        dn_r[j+1]    <= dn_r[j];
        dneg_r[j+1]  <= dneg_r[j];
        dside_r[j+1] <= dside_r[j];
        for (int k = 0; k < 4; k++) begin
          if (drem_r[j][k] >= (38'({dn_r[j], 14'd0}) >> j)) begin
            drem_r[j+1][k] <= drem_r[j][k] - (38'({dn_r[j], 14'd0}) >> j);
            dq_r[j+1][k]   <= {dq_r[j][k][13:0], 1'b1};
          end else begin
            drem_r[j+1][k] <= drem_r[j][k];
            dq_r[j+1][k]   <= {dq_r[j][k][13:0], 1'b0};
          end
        end
      end

      // Clamp and apply the branch sign.
      oside_r <= dside_r[DivSteps];
      for (int k = 0; k < 4; k++) begin
        if (dq_r[DivSteps][k] > 15'd16384) begin
          quat_r[k] <= dneg_r[DivSteps][k] ? 16'(-17'sd16384) : 16'd16384;
        end else if (dneg_r[DivSteps][k]) begin
          quat_r[k] <= 16'(17'd0 - {2'b00, dq_r[DivSteps][k]});
        end else begin
          quat_r[k] <= {1'b0, dq_r[DivSteps][k]};
        end
      end
    end
  end

  // Result channel: x, y, z, w are components 1, 2, 3, 0.
  assign out_tvalid = out_v_r;
  assign out_tdata  = {quat_r[0], quat_r[3], quat_r[2], quat_r[1],
                       oside_r.tz, oside_r.ty, oside_r.tx};

`ifndef NO_ASSERTIONS
  // Every quaternion field stays within unit range.
  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(quat_r[0]) >= -16384 && $signed(quat_r[0]) <= 16384 &&
                    $signed(quat_r[1]) >= -16384 && $signed(quat_r[1]) <= 16384 &&
                    $signed(quat_r[2]) >= -16384 && $signed(quat_r[2]) <= 16384 &&
                    $signed(quat_r[3]) >= -16384 && $signed(quat_r[3]) <= 16384))
    else $error("quaternion field out of range");

  // Each numerator yields a quotient that fits the divider.
  a_div_fit: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[0] |-> ({1'b0, drem_r[0][0]} < {dn_r[0], 15'd0} &&
                 {1'b0, drem_r[0][1]} < {dn_r[0], 15'd0} &&
                 {1'b0, drem_r[0][2]} < {dn_r[0], 15'd0} &&
                 {1'b0, drem_r[0][3]} < {dn_r[0], 15'd0}))
    else $error("divider quotient overflow");

  // The winning branch component is never negated.
  a_best_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r[0] |-> !neg2_r[0][sum_best_r])
    else $error("winning component has negative sign");

  // The norm is never zero for a valid pose.
  a_norm_nz: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[0] |-> (dn_r[0] != 24'd0))
    else $error("zero quaternion norm");
`endif

endmodule

// ===== test/tb_rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the rotation matrix to quaternion unit
// Drives pose requests through the stream ports, predicts each quaternion
// with an integer square root model and checks results in order.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  localparam int Latency    = 67;
  localparam int WatchLimit = 20000;
  localparam int ExpDepth   = 2048;

  // Result fields from the lowest bit up: tx, ty, tz, qx, qy, qz, qw.
  typedef struct packed {
    logic [15:0] qw;
    logic [15:0] qz;
    logic [15:0] qy;
    logic [15:0] qx;
    logic [31:0] tz;
    logic [31:0] ty;
    logic [31:0] tx;
  } pose_result_t;

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Work out the quaternion and passed-through translation of one pose.
  function automatic pose_result_t quaternion_of(logic [InW-1:0] d);
    longint m[9];
    longint s[4];
    longint unsigned r[4];
    longint unsigned total;
    longint unsigned nrm;
    longint unsigned mag;
    longint dif[4];
    bit neg[4];
    logic [15:0] q[4];
    int best;
    pose_result_t res;
    total = 0;
    best  = 0;
    for (int k = 0; k < 9; k++) m[k] = longint'($signed(d[16*k +: 16]));
    s[0] =  m[0] + m[4] + m[8] + 16384;
    s[1] =  m[0] - m[4] - m[8] + 16384;
    s[2] = -m[0] + m[4] - m[8] + 16384;
    s[3] = -m[0] - m[4] + m[8] + 16384;
    for (int k = 0; k < 4; k++) begin
      r[k]  = int_sqrt((s[k] > 0 ? longint'(s[k]) : 0) << 28);
      total += r[k] * r[k];
    end
    for (int k = 1; k < 4; k++) if (r[k] > r[best]) best = k;
    // Sign terms of the winning branch; a zero term counts as positive.
    case (best)
      0: begin
        dif[0] = 0; dif[1] = m[7] - m[5]; dif[2] = m[2] - m[6]; dif[3] = m[3] - m[1];
      end
      1: begin
        dif[1] = 0; dif[0] = m[7] - m[5]; dif[2] = m[3] + m[1]; dif[3] = m[2] + m[6];
      end
      2: begin
        dif[2] = 0; dif[0] = m[2] - m[6]; dif[1] = m[3] + m[1]; dif[3] = m[7] + m[5];
      end
      default: begin
        dif[3] = 0; dif[0] = m[3] - m[1]; dif[1] = m[6] + m[2]; dif[2] = m[7] + m[5];
      end
    endcase
    nrm = int_sqrt(total);
    for (int k = 0; k < 4; k++) begin
      neg[k] = dif[k] < 0;
      mag    = (nrm != 0) ? (r[k] * 16384 + nrm / 2) / nrm : 0;
      if (mag > 16384) mag = 16384;
      q[k] = neg[k] ? 16'(-mag) : 16'(mag);
    end
    res.tx = d[144 +: 32];
    res.ty = d[176 +: 32];
    res.tz = d[208 +: 32];
    res.qx = q[1];
    res.qy = q[2];
    res.qz = q[3];
    res.qw = q[0];
    return res;
  endfunction

  // Holds expected quaternions in request order and compares results.
  class quat_scoreboard;
    pose_result_t expect_buf[ExpDepth];
    int wr_cnt;
    int rd_cnt;
    int errors;

    function new();
      errors = 0;
      wr_cnt = 0;
      rd_cnt = 0;
    endfunction

    function int outstanding();
      return wr_cnt - rd_cnt;
    endfunction

    function void note_pose(logic [InW-1:0] d);
      expect_buf[wr_cnt % ExpDepth] = quaternion_of(d);
      wr_cnt++;
    endfunction

    function void check_result(logic [OutW-1:0] d);
      pose_result_t got;
      pose_result_t want;
      got = d;
      if (wr_cnt == rd_cnt) begin
        report_mismatch("unexpected result", 0, d);
        return;
      end
      want = expect_buf[rd_cnt % ExpDepth];
      rd_cnt++;
      if (got.tx != want.tx) report_mismatch("tx", want.tx, got.tx);
      if (got.ty != want.ty) report_mismatch("ty", want.ty, got.ty);
      if (got.tz != want.tz) report_mismatch("tz", want.tz, got.tz);
      if (got.qx != want.qx) report_mismatch("quat_x", want.qx, got.qx);
      if (got.qy != want.qy) report_mismatch("quat_y", want.qy, got.qy);
      if (got.qz != want.qz) report_mismatch("quat_z", want.qz, got.qz);
      if (got.qw != want.qw) report_mismatch("quat_w", want.qw, got.qw);
    endfunction

    function void report_mismatch(string what, logic [OutW-1:0] want,
                                  logic [OutW-1:0] got);
      $display("mismatch %s: expected %h got %h", what, want, got);
      errors++;
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_tvalid;
  logic           in_tready;
  logic [InW-1:0] in_tdata;   // m00..m22, tx_in, ty_in, tz_in
  logic           out_tvalid;
  logic           out_tready;
  logic [OutW-1:0] out_tdata; // tx_out, ty_out, tz_out, quat_x..quat_w

  quat_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  rotation_matrix_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Note accepted requests and check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_pose(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n && quiet_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one pose request, idling first at random.
  task automatic send_pose(logic [15:0] e[9], logic [31:0] tx, logic [31:0] ty,
                           logic [31:0] tz);
    logic [InW-1:0] d;
    for (int k = 0; k < 9; k++) d[16*k +: 16] = e[k];
    d[144 +: 32] = tx;
    d[176 +: 32] = ty;
    d[208 +: 32] = tz;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] q14(int v);
    return 16'(v);
  endfunction

  // Rotation about one axis from a cosine and sine, plus random jitter.
  task automatic send_rotation(int axis, int c, int sn, int jitter);
    logic [15:0] e[9];
    int v[9];
    for (int k = 0; k < 9; k++) v[k] = 0;
    case (axis)
      0: begin v[0] = 16384; v[4] = c; v[5] = -sn; v[7] = sn; v[8] = c; end
      1: begin v[4] = 16384; v[0] = c; v[2] = sn; v[6] = -sn; v[8] = c; end
      default: begin v[8] = 16384; v[0] = c; v[1] = -sn; v[3] = sn; v[4] = c; end
    endcase
    for (int k = 0; k < 9; k++) begin
      v[k] += $urandom_range(2 * jitter) - jitter;
      if (v[k] > 16384) v[k] = 16384;
      if (v[k] < -16384) v[k] = -16384;
      e[k] = q14(v[k]);
    end
    send_pose(e, $urandom, $urandom, $urandom);
  endtask

  task automatic send_random_pose();
    logic [15:0] e[9];
    for (int k = 0; k < 9; k++)
      e[k] = ($urandom_range(9) == 0) ? 16'($urandom) : q14($urandom_range(32768) - 16384);
    send_pose(e, $urandom, $urandom, $urandom);
  endtask

  task automatic send_diag(int a, int b, int c, int off);
    logic [15:0] e[9];
    for (int k = 0; k < 9; k++) e[k] = q14(off);
    e[0] = q14(a); e[4] = q14(b); e[8] = q14(c);
    send_pose(e, $urandom, $urandom, $urandom);
  endtask

  // One phase of random traffic at the given idle and stall rates.
  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) != 0) begin
        int ang;
        ang = $urandom_range(6283) - 3141;
        send_rotation($urandom_range(2), $rtoi(16384.0 * $cos(ang / 1000.0)),
                      $rtoi(16384.0 * $sin(ang / 1000.0)), $urandom_range(3) * 4);
      end else begin
        send_random_pose();
      end
    end
  endtask

  initial begin
    board          = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, half turns on each axis, extremes and ties.
    send_diag(16384, 16384, 16384, 0);
    send_diag(16384, -16384, -16384, 0);
    send_diag(-16384, 16384, -16384, 0);
    send_diag(-16384, -16384, 16384, 0);
    send_diag(0, 0, 0, 0);
    send_diag(-16384, -16384, -16384, 0);
    send_diag(-16384, -16384, -16384, -16384);
    send_diag(16384, 16384, 16384, 16384);
    send_diag(-16384, -16384, -16384, 16384);
    send_diag(0, 0, 0, -32768);
    send_diag(-32768, -32768, -32768, 32767);
    send_diag(32767, 32767, 32767, -1);
    send_diag(0, 0, -16384, 5);
    send_rotation(0, 0, 16384, 0);
    send_rotation(1, 0, -16384, 0);
    send_rotation(2, 0, 16384, 0);
    send_rotation(2, -11585, 11585, 0);
    send_rotation(0, 11585, -11585, 0);
    send_rotation(1, -16384, 0, 0);

    run_phase(0, 0, 400);
    run_phase(74, 0, 300);
    run_phase(0, 74, 300);
    run_phase(16, 16, 300);
    in_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/rmq_pkg.sv
src/rotation_matrix_to_quaternion_unit.sv
test/tb_rotation_matrix_to_quaternion_unit.sv
